[design/sdes_pkg.sv]
package sdes_pkg;

    // phase codes
    localparam logic [2:0] PH_OFF   = 3'd0;
    localparam logic [2:0] PH_START = 3'd1;
    localparam logic [2:0] PH_READY = 3'd2;
    localparam logic [2:0] PH_OPER  = 3'd3;
    localparam logic [2:0] PH_FAULT = 3'd4;

    // status word bits
    localparam int unsigned ST_FAULT_BIT   = 3;
    localparam int unsigned ST_QSTOP_BIT   = 5;
    localparam int unsigned ST_NOTOP_BIT   = 6;
    localparam int unsigned ST_ARRIVED_BIT = 10;
    localparam logic [15:0] ST_READY_MASK  = 16'h004f;

    // low nibble patterns: switch-on ready, switched on, operation enabled
    localparam logic [3:0] PAT_ON_READY = 4'b0001;
    localparam logic [3:0] PAT_ON       = 4'b0011;
    localparam logic [3:0] PAT_ENABLED  = 4'b0111;

    // control word bits
    localparam logic [7:0] CW_START = 8'h01;
    localparam logic [7:0] CW_MAIN  = 8'h02;
    localparam logic [7:0] CW_QSTOP = 8'h04;
    localparam logic [7:0] CW_OPER  = 8'h08;
    localparam logic [7:0] CW_RESET = 8'h80;

    localparam logic [3:0] MODE_IDLE     = 4'd0;
    localparam logic [3:0] MODE_POSITION = 4'd8;

    localparam logic [15:0] TIMER_MAX = 16'hffff;

    localparam logic [15:0] RST_HOLD_OFF  = 16'd1000;
    localparam logic [15:0] RST_RELOAD    = 16'd800;
    localparam logic [19:0] RST_MOVE_STEP = 20'd1000;
    localparam logic [15:0] RST_TOLERANCE = 16'd100;

    typedef struct packed {
        logic [15:0] hold_off_cycles;
        logic [15:0] retry_reload;
        logic [19:0] move_step;
        logic [15:0] arrive_tolerance;
    } t_cfg;

    typedef struct packed {
        logic [2:0]         phase;
        logic [7:0]         ctl_bits;
        logic [3:0]         mode;
        logic signed [31:0] target;
        logic signed [31:0] last_target;
        logic [15:0]        last_status;
        logic [15:0]        cycle_timer;
        logic               first_cycle;
        logic               stop_sent;
    } t_seq_state;

endpackage

[design/servo_drive_enable_sequencer.sv]
// Master-side enable sequencer for a servo drive, run once per bus cycle.
// Each input beat (status word, actual position, error code, stop request)
// is folded into the sequencer state in the cycle it is accepted, and the
// result beat (control word, mode, target, phase) is shown in the following
// cycle from the state registers themselves. One beat per clock is sustained: a
// new beat is taken whenever the result register is empty or is being taken
// in the same cycle, so a stall on the result side stalls the input side in
// that same cycle. The path that sets the clock is the 33-bit position error
// and tolerance compare that picks the next target. Configuration writes are
// registered and must be made while no result is pending.
module servo_drive_enable_sequencer
    import sdes_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,

    // configuration write port
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [19:0]        i_cfg_data,

    // input channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [15:0]        i_status_in,
    input  logic signed [31:0] i_position_in,
    input  logic [15:0]        i_drive_error,
    input  logic               i_stop_request,

    // result channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [7:0]         o_control_out,
    output logic [3:0]         o_mode_out,
    output logic signed [31:0] o_target_out,
    output logic [2:0]         o_phase_out
);

    // register indexes
    localparam logic [1:0] CFG_HOLD_OFF  = 2'd0;
    localparam logic [1:0] CFG_RELOAD    = 2'd1;
    localparam logic [1:0] CFG_MOVE_STEP = 2'd2;
    localparam logic [1:0] CFG_TOLERANCE = 2'd3;

    t_cfg       r_cfg;
    t_seq_state r_state;
    t_seq_state n_state;
    logic       r_out_valid;
    logic       in_take;

    // input beat may enter when the result slot is free or drains now
    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_take    = i_in_valid && !o_in_stall;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hold_off_cycles  <= RST_HOLD_OFF;
            r_cfg.retry_reload     <= RST_RELOAD;
            r_cfg.move_step        <= RST_MOVE_STEP;
            r_cfg.arrive_tolerance <= RST_TOLERANCE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_HOLD_OFF:  r_cfg.hold_off_cycles  <= i_cfg_data[15:0];
                CFG_RELOAD:    r_cfg.retry_reload     <= i_cfg_data[15:0];
                CFG_MOVE_STEP: r_cfg.move_step        <= i_cfg_data;
                CFG_TOLERANCE: r_cfg.arrive_tolerance <= i_cfg_data[15:0];
                default:       r_cfg.hold_off_cycles  <= r_cfg.hold_off_cycles;
            endcase
        end
    end

    // next state for the beat at the input ports
    sdes_core u_core (
        .i_state        (r_state),
        .i_cfg          (r_cfg),
        .i_status_in    (i_status_in),
        .i_position_in  (i_position_in),
        .i_drive_error  (i_drive_error),
        .i_stop_request (i_stop_request),
        .o_state        (n_state)
    );

    // sequencer state doubles as the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase       <= PH_OFF;
            r_state.ctl_bits    <= 8'h00;
            r_state.mode        <= MODE_IDLE;
            r_state.target      <= 32'sd0;
            r_state.last_target <= 32'sd0;
            r_state.last_status <= 16'h0000;
            r_state.cycle_timer <= 16'h0000;
            r_state.first_cycle <= 1'b1;
            r_state.stop_sent   <= 1'b0;
            r_out_valid         <= 1'b0;
        end else begin
            if (in_take) begin
                r_state <= n_state;
            end
            if (in_take) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_control_out = r_state.ctl_bits;
    assign o_mode_out    = r_state.mode;
    assign o_target_out  = r_state.target;
    assign o_phase_out   = r_state.phase;

`ifndef ASSERT_OFF
    // every accepted beat yields a result beat next cycle
    a_take_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> r_out_valid)
        else $error("accepted beat produced no result");

    // a held result blocks the input side
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> (r_out_valid && $stable(r_state)))
        else $error("pending result overwritten");

    // stop is latched for good
    a_stop_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.stop_sent |=> r_state.stop_sent)
        else $error("stop latch released");

    // only idle or position mode is ever sent
    a_mode_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.mode == MODE_IDLE) || (r_state.mode == MODE_POSITION))
        else $error("illegal mode");

    // phase stays within the defined codes
    a_phase_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.phase <= PH_FAULT)
        else $error("illegal phase");
`endif

endmodule

[design/sdes_core.sv]
module sdes_core
    import sdes_pkg::*;
(
    input  t_seq_state         i_state,
    input  t_cfg               i_cfg,
    input  logic [15:0]        i_status_in,
    input  logic signed [31:0] i_position_in,
    input  logic [15:0]        i_drive_error,
    input  logic               i_stop_request,
    output t_seq_state         o_state
);

    logic               not_rdy;
    logic               low_ok;
    logic               lp_on_ready;
    logic               lp_on;
    logic               lp_enabled;
    logic               st_fault;
    logic [15:0]        timer_inc;
    logic signed [32:0] pos_diff;
    logic [32:0]        pos_err;
    logic               arrived;

    assign not_rdy     = (i_status_in & ST_READY_MASK) == 16'h0000;
    assign low_ok      = !i_status_in[ST_NOTOP_BIT] && i_status_in[ST_QSTOP_BIT];
    assign lp_on_ready = low_ok && (i_status_in[3:0] == PAT_ON_READY);
    assign lp_on       = low_ok && (i_status_in[3:0] == PAT_ON);
    assign lp_enabled  = low_ok && (i_status_in[3:0] == PAT_ENABLED);
    assign st_fault    = i_status_in[ST_FAULT_BIT];

    assign timer_inc = (i_state.cycle_timer < TIMER_MAX) ? i_state.cycle_timer + 16'd1
                                                         : i_state.cycle_timer;

    // exact distance from last target
    assign pos_diff = 33'(i_position_in) - 33'(i_state.last_target);
    assign pos_err  = pos_diff[32] ? 33'(-pos_diff) : 33'(pos_diff);
    assign arrived  = i_status_in[ST_ARRIVED_BIT]
                      && (pos_err < {17'd0, i_cfg.arrive_tolerance});

    always_comb begin
        o_state             = i_state;
        o_state.first_cycle = 1'b0;
        o_state.last_status = i_status_in;
        o_state.cycle_timer = timer_inc;

        // status change handling
        if (!i_state.first_cycle && (i_status_in != i_state.last_status)) begin
            if (not_rdy) begin
                o_state.phase = PH_OFF;
            end else if (st_fault || lp_on_ready || lp_on || lp_enabled) begin
                o_state.phase = i_state.phase;
            end else if (!i_status_in[ST_NOTOP_BIT] && !i_status_in[ST_QSTOP_BIT]) begin
                o_state.phase = PH_FAULT;
            end
        end

        if ((i_drive_error != 16'h0000) || st_fault) begin
            o_state.ctl_bits = CW_RESET;
        end else begin
            o_state.ctl_bits = i_state.ctl_bits & ~CW_RESET;
        end

        if (timer_inc > i_cfg.hold_off_cycles) begin
            if (i_stop_request || i_state.stop_sent) begin
                if (!i_state.stop_sent) begin
                    o_state.stop_sent = 1'b1;
                    o_state.mode      = MODE_IDLE;
                    o_state.ctl_bits  = o_state.ctl_bits
                                        & ~(CW_START | CW_OPER | CW_QSTOP | CW_RESET);
                    if (lp_on_ready) begin
                        o_state.ctl_bits = o_state.ctl_bits & ~CW_MAIN;
                    end else begin
                        o_state.ctl_bits = o_state.ctl_bits | CW_MAIN;
                    end
                end
            end else begin
                case (o_state.phase)
                    PH_OFF: begin
                        o_state.mode        = MODE_IDLE;
                        o_state.ctl_bits    = o_state.ctl_bits | CW_MAIN | CW_QSTOP;
                        o_state.cycle_timer = i_cfg.retry_reload;
                        if (!not_rdy) o_state.phase = PH_START;
                    end
                    PH_START: begin
                        o_state.ctl_bits    = o_state.ctl_bits | CW_START;
                        o_state.cycle_timer = i_cfg.retry_reload;
                        if (lp_on) o_state.phase = PH_READY;
                    end
                    PH_READY: begin
                        o_state.ctl_bits    = o_state.ctl_bits | CW_OPER;
                        o_state.cycle_timer = i_cfg.retry_reload;
                        if (lp_enabled) begin
                            o_state.phase       = PH_OPER;
                            o_state.target      = i_position_in;
                            o_state.last_target = i_position_in;
                            o_state.mode        = MODE_POSITION;
                        end
                    end
                    PH_OPER: begin
                        if (arrived) begin
                            o_state.target      = i_position_in + 32'(i_cfg.move_step);
                            o_state.last_target = i_state.last_target
                                                  + 32'(i_cfg.move_step);
                        end
                    end
                    default: begin
                        // fault and unused codes wait for a not-ready status
                    end
                endcase
            end
        end
    end

endmodule
